// ===== hdl/ssk_pkg.sv =====
`timescale 1ns / 1ps

package ssk_pkg;

    // Default capacity of the table, in keys and in dense slots.
    localparam int KEYS_DEF = 1024;

    // Fixed field widths.
    localparam int HANDLE_BITS = 32;
    localparam int KIND_W      = 2;
    localparam int KEY_W       = 10;
    localparam int SLOT_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_SLOT   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_LOOKUP = 5'b01000,
        ST_RELINK = 5'b10000
    } state_t;

endpackage

// ===== hdl/ssk_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port synchronous memory: one write port, one read port,
// read data registered.
module ssk_ram #(
    parameter int WIDTH  = ssk_pkg::HANDLE_BITS,
    parameter int DEPTH  = ssk_pkg::KEYS_DEF,
    parameter int ADDR_W = $clog2(ssk_pkg::KEYS_DEF)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sparse_set_key_table.sv =====
`timescale 1ns / 1ps

// Sparse-set key table: maps keys to handles, with a dense slot array that
// can be walked by slot number.
//
// Command channel: an item (kind, key, handle_in, slot) is accepted at a
// rising edge where start is high and busy is low; busy stays high until
// the item's result has been produced. Result channel: done is high for
// exactly one cycle with status, handle_out, key_out and key_count valid.
// The receiver cannot stall, so the result is taken in that cycle.
//
// Work states: a lookup passes through EXEC and LOOKUP, and a remove that
// moves the last slot into the freed one through EXEC and RELINK; every
// other item ends in EXEC. The key-index read is registered, lookup adds
// a dependent slot read and a moving remove a second key-index write. The
// result is taken at the edge that ends the cycle after the last work
// cycle, the first edge at which the next item can be accepted.
//
// Reset: the presence bits live beside the slot indexes in the key-index
// memory, so after reset the block sweeps it clear, one key per cycle,
// from key 0 to KEYS-1, with busy held high. The slot memory is never
// cleared; its entries are read only below the live count.
module sparse_set_key_table #(
    parameter int KEYS = ssk_pkg::KEYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ssk_pkg::KIND_W-1:0]       kind,
    input  logic [ssk_pkg::KEY_W-1:0]        key,
    input  logic [ssk_pkg::HANDLE_BITS-1:0]  handle_in,
    input  logic [ssk_pkg::SLOT_W-1:0]       slot,
    output logic                             done,
    output logic [ssk_pkg::STATUS_W-1:0]     status,
    output logic [ssk_pkg::HANDLE_BITS-1:0]  handle_out,
    output logic [ssk_pkg::KEY_W-1:0]        key_out,
    output logic [ssk_pkg::COUNT_OUT_W-1:0]  key_count
);

    import ssk_pkg::*;

    // Index into the stores, the count (which reaches KEYS itself), and a
    // width wide enough to compare keys and slots against both.
    localparam int IDX_W  = $clog2(KEYS);
    localparam int CNT_W  = $clog2(KEYS + 1);
    localparam int CMP_W  = (CNT_W > KEY_W) ? CNT_W : KEY_W;
    localparam int KWORD_W = IDX_W + 1;
    localparam int SWORD_W = KEY_W + HANDLE_BITS;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       clr_addr_reg;

    // Item being worked on.
    kind_t                  kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   load;

    // Context kept for the relink step of a remove.
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [KEY_W-1:0]       moved_reg, moved_next;

    // Result registers.
    logic                   done_reg;
    status_t                status_reg;
    logic [HANDLE_BITS-1:0] handle_out_reg;
    logic [KEY_W-1:0]       key_out_reg;
    logic [COUNT_OUT_W-1:0] key_count_reg;

    logic                   fin;
    status_t                res_status;
    logic [HANDLE_BITS-1:0] res_handle;
    logic [KEY_W-1:0]       res_key;

    // Memory ports.
    logic                   key_we;
    logic [IDX_W-1:0]       key_waddr, key_raddr;
    logic [KWORD_W-1:0]     key_wdata, key_rdata;
    logic                   slot_we;
    logic [IDX_W-1:0]       slot_waddr, slot_raddr;
    logic [SWORD_W-1:0]     slot_wdata, slot_rdata;

    logic                   kpres;
    logic [IDX_W-1:0]       kidx;
    logic [KEY_W-1:0]       skey;
    logic [HANDLE_BITS-1:0] shandle;
    logic [IDX_W-1:0]       last_addr;
    logic                   key_ok, slot_ok, count_full, moved_ok;

    // Key-index memory: {present, slot index} per key.
    ssk_ram #(
        .WIDTH  (KWORD_W),
        .DEPTH  (KEYS),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk    (clk),
        .we     (key_we),
        .waddr  (key_waddr),
        .wdata  (key_wdata),
        .raddr  (key_raddr),
        .rdata  (key_rdata)
    );

    // Dense slot memory: {key, handle} per slot.
    ssk_ram #(
        .WIDTH  (SWORD_W),
        .DEPTH  (KEYS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk    (clk),
        .we     (slot_we),
        .waddr  (slot_waddr),
        .wdata  (slot_wdata),
        .raddr  (slot_raddr),
        .rdata  (slot_rdata)
    );

    assign kpres   = key_rdata[IDX_W];
    assign kidx    = key_rdata[IDX_W-1:0];
    assign skey    = slot_rdata[SWORD_W-1:HANDLE_BITS];
    assign shandle = slot_rdata[HANDLE_BITS-1:0];

    assign last_addr  = IDX_W'(count_reg - CNT_W'(1));
    assign key_ok     = CMP_W'(key_reg) < CMP_W'(KEYS);
    // The count never exceeds KEYS, so a slot below the count is in range.
    assign slot_ok    = CMP_W'(slot_reg) < CMP_W'(count_reg);
    assign count_full = count_reg == CNT_W'(KEYS);
    assign moved_ok   = CMP_W'(skey) < CMP_W'(KEYS);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        moved_next = moved_reg;
        load       = 1'b0;
        fin        = 1'b0;
        res_status = STAT_DONE;
        res_handle = '0;
        res_key    = '0;

        key_we     = 1'b0;
        key_waddr  = IDX_W'(key_reg);
        key_wdata  = '0;
        key_raddr  = IDX_W'(key);
        slot_we    = 1'b0;
        slot_waddr = kidx;
        slot_wdata = {key_reg, handle_reg};
        // At accept the slot memory fetches either the requested slot or the
        // last live slot, which a remove will move into the freed place.
        slot_raddr = (kind == KIND_READ) ? IDX_W'(slot) : last_addr;

        case (state_reg)
            ST_CLEAR:
            begin
                key_we    = 1'b1;
                key_waddr = clr_addr_reg;
                key_wdata = '0;
                if (clr_addr_reg == IDX_W'(KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    load       = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
                if (kind_reg == KIND_READ)
                begin
                    if (slot_ok)
                    begin
                        res_handle = shandle;
                        res_key    = skey;
                    end
                    else
                    begin
                        res_status = STAT_SLOT;
                    end
                end
                else if (!key_ok)
                begin
                    res_status = STAT_RANGE;
                end
                else if (kind_reg == KIND_ADD)
                begin
                    if (kpres)
                    begin
                        // Update in place; the slot already holds this key.
                        slot_we    = 1'b1;
                        slot_waddr = kidx;
                    end
                    else if (!count_full)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = count_reg[IDX_W-1:0];
                        key_we     = 1'b1;
                        key_wdata  = {1'b1, count_reg[IDX_W-1:0]};
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (!kpres)
                begin
                    res_status = STAT_ABSENT;
                end
                else if (kind_reg == KIND_LOOKUP)
                begin
                    fin        = 1'b0;
                    slot_raddr = kidx;
                    state_next = ST_LOOKUP;
                end
                else
                begin
                    // Remove: clear the key, and move the last slot into the
                    // freed one unless the freed one is the last.
                    key_we     = 1'b1;
                    key_wdata  = {1'b0, kidx};
                    count_next = count_reg - CNT_W'(1);
                    if (kidx != last_addr)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = kidx;
                        slot_wdata = slot_rdata;
                        idx_next   = kidx;
                        moved_next = skey;
                        if (moved_ok)
                        begin
                            fin        = 1'b0;
                            state_next = ST_RELINK;
                        end
                    end
                end
            end

            ST_LOOKUP:
            begin
                fin        = 1'b1;
                res_handle = shandle;
                state_next = ST_IDLE;
            end

            ST_RELINK:
            begin
                key_we     = 1'b1;
                key_waddr  = IDX_W'(moved_reg);
                key_wdata  = {1'b1, idx_reg};
                fin        = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            count_reg    <= '0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= fin;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_t'(kind);
            key_reg    <= key;
            handle_reg <= handle_in;
            slot_reg   <= slot;
        end
        idx_reg   <= idx_next;
        moved_reg <= moved_next;
        if (fin)
        begin
            status_reg     <= res_status;
            handle_out_reg <= res_handle;
            key_out_reg    <= res_key;
            key_count_reg  <= COUNT_OUT_W'(count_next);
        end
    end

    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign key_out    = key_out_reg;
    assign key_count  = key_count_reg;

    // A result comes only out of a work state.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_LOOKUP ||
                  $past(state_reg) == ST_RELINK))
        else $error("result strobe without a work state");

    // The live count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(KEYS))
        else $error("live count beyond capacity");

    // An accepted item always starts its work in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start");

    // Slot-beyond-count is reported only for a read-slot item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_SLOT) |-> (kind_reg == KIND_READ))
        else $error("slot status for a non-read item");

endmodule
